@@ hw/rtl/gcd_pkg.sv @@
// ----------------------------------------------------------------------------
// Great-circle distance package
// Shared widths, fixed-point constants and arithmetic helpers for the
// haversine distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

  // Field widths.
  localparam int unsigned LatW    = 38;
  localparam int unsigned LonW    = 39;
  localparam int unsigned DistW   = 35;
  localparam int unsigned RadiusW = 23;

  // Datapath widths: CORDIC and product word, unsigned Q30 value, scaled radius.
  localparam int unsigned CW   = 34;
  localparam int unsigned QW   = 31;
  localparam int unsigned RkW  = 33;

  // Default CORDIC iteration count.
  localparam int unsigned CORDIC_STEPS = 32;

  // Angle constants in nanodegrees.
  localparam logic signed [42:0] FULL_TURN_ND   = 43'sd360000000000;
  localparam logic signed [42:0] HALF_TURN_ND   = 43'sd180000000000;
  localparam logic [37:0]        HALF_TURN_MAG  = 38'd180000000000;
  localparam logic [37:0]        RIGHT_ANGLE_ND = 38'd90000000000;

  // pi / 180e9 scaled by 2^61.
  localparam logic [25:0] RAD_PER_ND_Q61 = 26'd40244553;

  // Q30 constants.
  localparam logic signed [CW-1:0] GAIN_INV_Q30 = 34'sd652032874;
  localparam logic [QW-1:0]        HALF_PI_Q30  = 31'd1686629713;
  localparam logic [QW-1:0]        ONE_Q30      = 31'd1073741824;

  // Radius reset value in millimetres.
  localparam logic [RkW-1:0] RADIUS_RESET_MM = 33'd6371000000;

  // Arctangent of 2^-i for the first ten iterations, Q30.
  localparam logic [29:0] ATAN_HEAD [10] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149
  };

  // CORDIC step angle for iteration i.
  function automatic logic signed [CW-1:0] step_angle(input int i);
    logic signed [CW-1:0] r;
    if (i < 10) begin
      r = CW'(ATAN_HEAD[i]);
    end else if (i <= 30) begin
      r = CW'(1) << (30 - i);
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // Fold an angle into [-180, 180] degrees and return its magnitude.
  function automatic logic [37:0] fold_mag(input logic signed [40:0] d);
    logic signed [42:0] dx;
    logic signed [42:0] r;
    dx = 43'(d);
    if (dx >= FULL_TURN_ND) begin
      r = dx - FULL_TURN_ND;
    end else if (dx >= 0) begin
      r = dx;
    end else if (dx + FULL_TURN_ND >= 0) begin
      r = dx + FULL_TURN_ND;
    end else begin
      r = dx + FULL_TURN_ND + FULL_TURN_ND;
    end
    if (r > HALF_TURN_ND) begin
      r = FULL_TURN_ND - r;
    end
    return 38'(r);
  endfunction

  // Convert a nanodegree magnitude to Q30 radians, full or half angle.
  function automatic logic [QW-1:0] nd_to_q30(input logic [37:0] m, input logic half);
    logic [63:0] p;
    logic [QW-1:0] r;
    p = 64'(m) * 64'(RAD_PER_ND_Q61);
    if (half) begin
      p = p + 64'h0000_0000_8000_0000;
      r = QW'(p >> 32);
    end else begin
      p = p + 64'h0000_0000_4000_0000;
      r = QW'(p >> 31);
    end
    return r;
  endfunction

  // Q30 product, rounded half up.
  function automatic logic signed [CW-1:0] qmul(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    p = (2*CW)'(a) * (2*CW)'(b);
    p = p + 68'sd536870912;
    return CW'(p >>> 30);
  endfunction

endpackage

@@ hw/rtl/gcd_cordic.sv @@
// ----------------------------------------------------------------------------
// CORDIC pipeline
// One iteration per register stage, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module gcd_cordic #(
  parameter int unsigned STEPS  = gcd_pkg::CORDIC_STEPS,
  parameter bit          VECTOR = 1'b0
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [gcd_pkg::CW-1:0] x_i,
  input  logic signed [gcd_pkg::CW-1:0] y_i,
  input  logic signed [gcd_pkg::CW-1:0] z_i,
  output logic signed [gcd_pkg::CW-1:0] x_o,
  output logic signed [gcd_pkg::CW-1:0] y_o,
  output logic signed [gcd_pkg::CW-1:0] z_o
);
  import gcd_pkg::*;

  logic signed [CW-1:0] x_q [STEPS];
  logic signed [CW-1:0] y_q [STEPS];
  logic signed [CW-1:0] z_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0] x_in, y_in, z_in;
    logic signed [CW-1:0] x_d, y_d, z_d;
    logic                 pos;

    // Stage input comes from the port or the previous iteration.
    if (i == 0) begin : g_first
      assign x_in = x_i;
      assign y_in = y_i;
      assign z_in = z_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    // Rotation steers by the residual angle, vectoring by the sign of y.
    assign pos = VECTOR ? !(y_in > 0) : (z_in >= 0);

    // One micro-rotation with arithmetic shifts.
    always_comb begin
      if (pos) begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - step_angle(i);
      end else begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + step_angle(i);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
        z_q[i] <= z_d;
      end
    end
  end

  assign x_o = x_q[STEPS-1];
  assign y_o = y_q[STEPS-1];
  assign z_o = z_q[STEPS-1];

endmodule

@@ hw/rtl/gcd_isqrt.sv @@
// ----------------------------------------------------------------------------
// Square root pipeline
// Rounded square root of a Q30 value, one result bit per register stage.
// ----------------------------------------------------------------------------
module gcd_isqrt (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [gcd_pkg::QW-1:0]   a_i,
  output logic [gcd_pkg::QW-1:0]   root_o
);
  import gcd_pkg::*;

  localparam int unsigned N  = 31;
  localparam int unsigned RW = 62;

  logic [RW-1:0] rem_q  [N];
  logic [RW-1:0] root_q [N];
  logic [QW-1:0] out_q;

  for (genvar k = 0; k < N; k++) begin : g_bit
    localparam logic [RW-1:0] BIT = RW'(1) << (60 - 2 * k);
    logic [RW-1:0] rem_in, root_in, trial;
    logic [RW-1:0] rem_d, root_d;

    // The radicand is the input shifted up by 30 bits.
    if (k == 0) begin : g_first
      assign rem_in  = RW'({a_i, 30'b0});
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // Trial subtraction decides one bit of the root.
    assign trial = root_in + BIT;
    always_comb begin
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = (root_in >> 1) + BIT;
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  // Round to nearest from the final remainder.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (rem_q[N-1] > root_q[N-1]) begin
        out_q <= QW'(root_q[N-1] + RW'(1));
      end else begin
        out_q <= QW'(root_q[N-1]);
      end
    end
  end

  assign root_o = out_q;

endmodule

@@ hw/rtl/great_circle_distance_core.sv @@
// Throughput: one item per cycle; the CORDIC chains and the 32-stage square
// roots are fully pipelined, and the whole pipeline holds while a result is stalled.
// Reset clears all valid bits and sets the radius to 6371000 m.
// Data registers are not reset.
// ----------------------------------------------------------------------------
// Great-circle distance core
// Haversine distance between two points in nanodegrees, in millimetres.
// ----------------------------------------------------------------------------
module great_circle_distance_core #(
  parameter int unsigned CORDIC_STEPS = gcd_pkg::CORDIC_STEPS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gcd_pkg::RadiusW-1:0]       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [gcd_pkg::LatW-1:0]   lat_a_i,
  input  logic signed [gcd_pkg::LonW-1:0]   lon_a_i,
  input  logic signed [gcd_pkg::LatW-1:0]   lat_b_i,
  input  logic signed [gcd_pkg::LonW-1:0]   lon_b_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gcd_pkg::DistW-1:0]         distance_mm_o
);
  import gcd_pkg::*;

  localparam int unsigned LAT = 2 * CORDIC_STEPS + 41;

  logic           en;
  logic [LAT-1:0] vld_q;
  logic [RkW-1:0] rk_q, rk_d;

  // Pipeline advances unless a finished result is waiting.
  assign en          = ~vld_q[LAT-1] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // Radius register, kept scaled to millimetres.
  assign rk_d = cfg_we_i ? RkW'(cfg_wdata_i) * RkW'(1000) : rk_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rk_q <= RADIUS_RESET_MM;
    end else begin
      rk_q <= rk_d;
    end
  end

  // Stage 1: capture latitudes and coordinate differences.
  logic signed [LatW-1:0] la1_q, lb1_q;
  logic signed [LatW:0]   dlat1_q;
  logic signed [LonW:0]   dlon1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      la1_q   <= lat_a_i;
      lb1_q   <= lat_b_i;
      dlat1_q <= (LatW+1)'(lat_b_i) - (LatW+1)'(lat_a_i);
      dlon1_q <= (LonW+1)'(lon_b_i) - (LonW+1)'(lon_a_i);
    end
  end

  // Stage 2: fold into half turns; latitudes past a right angle are mirrored.
  logic [37:0] fa, fb;
  logic [37:0] ma2_q, mb2_q, mdlat2_q, mdlon2_q;
  logic [1:0]  neg2_q;
  assign fa = fold_mag(41'(la1_q));
  assign fb = fold_mag(41'(lb1_q));
  always_ff @(posedge clk_i) begin
    if (en) begin
      ma2_q    <= (fa > RIGHT_ANGLE_ND) ? HALF_TURN_MAG - fa : fa;
      mb2_q    <= (fb > RIGHT_ANGLE_ND) ? HALF_TURN_MAG - fb : fb;
      neg2_q   <= {fb > RIGHT_ANGLE_ND, fa > RIGHT_ANGLE_ND};
      mdlat2_q <= fold_mag(41'(dlat1_q));
      mdlon2_q <= fold_mag(41'(dlon1_q));
    end
  end

  // Stage 3: convert to Q30 radians, half angles for the differences.
  logic [QW-1:0] tha3_q, thb3_q, thlat3_q, thlon3_q;
  logic [1:0]    neg3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      tha3_q   <= nd_to_q30(ma2_q, 1'b0);
      thb3_q   <= nd_to_q30(mb2_q, 1'b0);
      thlat3_q <= nd_to_q30(mdlat2_q, 1'b1);
      thlon3_q <= nd_to_q30(mdlon2_q, 1'b1);
      neg3_q   <= neg2_q;
    end
  end

  // Sine and cosine lanes.
  logic signed [CW-1:0] cos_a, cos_b, sin_lat, sin_lon;
  gcd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_cos_a (
    .clk_i, .en_i(en), .x_i(GAIN_INV_Q30), .y_i('0), .z_i(CW'(tha3_q)),
    .x_o(cos_a), .y_o(), .z_o()
  );
  gcd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_cos_b (
    .clk_i, .en_i(en), .x_i(GAIN_INV_Q30), .y_i('0), .z_i(CW'(thb3_q)),
    .x_o(cos_b), .y_o(), .z_o()
  );
  gcd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_sin_lat (
    .clk_i, .en_i(en), .x_i(GAIN_INV_Q30), .y_i('0), .z_i(CW'(thlat3_q)),
    .x_o(), .y_o(sin_lat), .z_o()
  );
  gcd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_sin_lon (
    .clk_i, .en_i(en), .x_i(GAIN_INV_Q30), .y_i('0), .z_i(CW'(thlon3_q)),
    .x_o(), .y_o(sin_lon), .z_o()
  );

  // Mirror flags follow the cosine lanes.
  logic [1:0] neg_dl_q [CORDIC_STEPS];
  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_dl_q[0] <= neg3_q;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        neg_dl_q[i] <= neg_dl_q[i-1];
      end
    end
  end

  // Stage N: apply the sign of mirrored latitudes.
  logic signed [CW-1:0] ca_q, cb_q, sl_q, so_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ca_q <= neg_dl_q[CORDIC_STEPS-1][0] ? -cos_a : cos_a;
      cb_q <= neg_dl_q[CORDIC_STEPS-1][1] ? -cos_b : cos_b;
      sl_q <= sin_lat;
      so_q <= sin_lon;
    end
  end

  // Stage M1: cosine product and squared half-angle sines.
  logic signed [CW-1:0] cc_q, hl_q, ho_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      cc_q <= qmul(ca_q, cb_q);
      hl_q <= qmul(sl_q, sl_q);
      ho_q <= qmul(so_q, so_q);
    end
  end

  // Stage M2: longitude term.
  logic signed [CW-1:0] t_q, hl2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q   <= qmul(cc_q, ho_q);
      hl2_q <= hl_q;
    end
  end

  // Stage A: haversine term clamped to [0, 1] and its complement.
  logic signed [CW:0] a_sum;
  logic [QW-1:0]      a_d, a_q, b_q;
  assign a_sum = (CW+1)'(hl2_q) + (CW+1)'(t_q);
  always_comb begin
    if (a_sum < 0) begin
      a_d = '0;
    end else if (a_sum > (CW+1)'(ONE_Q30)) begin
      a_d = ONE_Q30;
    end else begin
      a_d = QW'(a_sum);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
      b_q <= ONE_Q30 - a_d;
    end
  end

  // Square roots of a and 1 - a.
  logic [QW-1:0] sa, sb;
  gcd_isqrt u_sqrt_a (.clk_i, .en_i(en), .a_i(a_q), .root_o(sa));
  gcd_isqrt u_sqrt_b (.clk_i, .en_i(en), .a_i(b_q), .root_o(sb));

  // Half central angle by vectoring.
  logic signed [CW-1:0] zang;
  gcd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_atan2 (
    .clk_i, .en_i(en), .x_i(CW'(sb)), .y_i(CW'(sa)), .z_i('0),
    .x_o(), .y_o(), .z_o(zang)
  );

  // Stage Z: clamp the half angle to [0, pi/2].
  logic [QW-1:0] zc_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (zang < 0) begin
        zc_q <= '0;
      end else if (zang > CW'(HALF_PI_Q30)) begin
        zc_q <= HALF_PI_Q30;
      end else begin
        zc_q <= QW'(zang);
      end
    end
  end

  // Stage D: scale by the radius and round to millimetres.
  logic [63:0]      prod;
  logic [DistW-1:0] dist_q;
  assign prod = 64'(rk_q) * 64'(zc_q) + 64'h0000_0000_1000_0000;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= prod[63:29];
    end
  end

  assign distance_mm_o = dist_q;

endmodule

@@ hw/rtl/gcd_checker.sv @@
// ----------------------------------------------------------------------------
// Great-circle distance checker
// Port-level checks on transfers and results, bound to the core.
// ----------------------------------------------------------------------------
module gcd_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [34:0] distance_mm_o
);

  localparam logic [34:0] DIST_MAX = 35'd26400000000;

  logic        in_xfer, out_xfer;
  logic [15:0] cnt_q;

  assign in_xfer  = in_valid_i & in_ready_o;
  assign out_xfer = out_valid_o & out_ready_i;

  // Items accepted and not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 16'(in_xfer) - 16'(out_xfer);
    end
  end

  // A result only appears for an item in flight.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 16'd0)
    else $error("result without an outstanding item");

  // With no result waiting, the input side is never stalled.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before transfer");

  // Distance never exceeds 26400000000 mm, a bound just above half the largest circumference.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distance_mm_o <= DIST_MAX)
    else $error("distance out of range");

endmodule

bind great_circle_distance_core gcd_assert u_gcd_assert (.*);
